/* hw/rtl/cdgfd_pkg.sv */
// cdgfd_pkg: shared constants, instruction codes and the controller/datapath
// command and status types of the cd+g frame decoder
// no dependencies
package cdgfd_pkg;

    localparam int unsigned SCREEN_COLUMNS = 320;
    localparam int unsigned SCREEN_ROWS    = 240;
    localparam int unsigned FRAME_SIZE     = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int unsigned ADDR_W         = $clog2(FRAME_SIZE);
    localparam int unsigned X_W            = 9;
    localparam int unsigned Y_W            = 8;
    localparam int unsigned TILE_W         = 9;
    localparam int unsigned PAT_W          = 72;
    localparam int unsigned PAT_IDX_W      = $clog2(PAT_W);

    // inner area, columns [INNER_X0, INNER_X1) and rows [INNER_Y0, INNER_Y1)
    localparam int unsigned INNER_X0 = 10;
    localparam int unsigned INNER_X1 = 310;
    localparam int unsigned INNER_Y0 = 12;
    localparam int unsigned INNER_Y1 = 228;

    localparam int unsigned TILE_COLS = 6;
    localparam int unsigned TILE_ROWS = 12;

    localparam logic [5:0] INSTR_MEM_PRESET    = 6'd1;
    localparam logic [5:0] INSTR_BORDER_PRESET = 6'd2;
    localparam logic [5:0] INSTR_TILE          = 6'd6;
    localparam logic [5:0] INSTR_TILE_XOR      = 6'd38;

    localparam logic OPC_PACKET = 1'b0;
    localparam logic OPC_READ   = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_READ,
        OP_FILL,
        OP_TILE,
        OP_XOR
    } t_op;

    typedef enum logic [1:0] {
        WK_CLEAR,
        WK_FILL,
        WK_TILE,
        WK_XOR
    } t_wr_kind;

    typedef enum logic [1:0] {
        AS_SWEEP,
        AS_TILE,
        AS_READ
    } t_addr_src;

    typedef struct packed {
        logic      load;
        logic      sweep_step;
        logic      tile_step;
        logic      rd_en;
        logic      wr_en;
        t_wr_kind  wr_kind;
        t_addr_src addr_src;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic sweep_last;
        logic tile_last;
    } t_dp_status;

endpackage

/* hw/rtl/cdgfd_datapath.sv */
// cdgfd_datapath: frame memory, sweep and tile counters, address and write data
// depends on cdgfd_pkg
module cdgfd_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cdgfd_pkg::t_dp_cmd   i_cmd,
    output cdgfd_pkg::t_dp_status o_status,
    input  logic                 i_opcode,
    input  logic [5:0]           i_instruction,
    input  logic [5:0]           i_first_byte,
    input  logic [5:0]           i_second_byte,
    input  logic [5:0]           i_third_byte,
    input  logic [5:0]           i_fourth_byte,
    input  logic [35:0]          i_pattern_top,
    input  logic [35:0]          i_pattern_bottom,
    input  logic [8:0]           i_read_column,
    input  logic [7:0]           i_read_row,
    output logic [5:0]           o_pixel_color,
    output logic                 o_read_done
);

    localparam int unsigned AW = cdgfd_pkg::ADDR_W;
    localparam int unsigned XW = cdgfd_pkg::X_W;
    localparam int unsigned YW = cdgfd_pkg::Y_W;
    localparam int unsigned TW = cdgfd_pkg::TILE_W;
    localparam int unsigned PW = cdgfd_pkg::PAT_IDX_W;

    logic [5:0]  r_mem [cdgfd_pkg::FRAME_SIZE];
    logic [5:0]  r_rdata;

    logic [XW-1:0] r_sx, n_sx;
    logic [YW-1:0] r_sy, n_sy;
    logic [2:0]    r_tp, n_tp;
    logic [3:0]    r_tr, n_tr;

    logic          r_is_read;
    logic          r_fill_inner;
    logic [5:0]    r_fill_color;
    logic [3:0]    r_color0;
    logic [3:0]    r_color1;
    logic [TW-1:0] r_tile_x0;
    logic [TW-1:0] r_tile_y0;
    logic [cdgfd_pkg::PAT_W-1:0] r_pattern;
    logic [XW-1:0] r_rd_x;
    logic [YW-1:0] r_rd_y;
    logic          r_rd_ok;

    logic [TW-1:0] w_tx, w_ty;
    logic          w_tile_ok;
    logic [PW-1:0] w_bit_idx;
    logic [5:0]    w_tile_color;
    logic          w_inner;
    logic [XW-1:0] w_ax;
    logic [YW-1:0] w_ay;
    logic [AW-1:0] w_addr;
    logic          w_we;
    logic [5:0]    w_wdata;
    logic          w_sweep_last;
    logic          w_tile_last;

    // operation decode of the item on the input ports
    always_comb begin
        o_status.sweep_last = w_sweep_last;
        o_status.tile_last  = w_tile_last;
        o_status.op = cdgfd_pkg::OP_NONE;
        if (i_opcode == cdgfd_pkg::OPC_READ) begin
            o_status.op = cdgfd_pkg::OP_READ;
        end else begin
            case (i_instruction)
                cdgfd_pkg::INSTR_MEM_PRESET: begin
                    if (i_second_byte == 6'd0) begin
                        o_status.op = cdgfd_pkg::OP_FILL;
                    end
                end
                cdgfd_pkg::INSTR_BORDER_PRESET: o_status.op = cdgfd_pkg::OP_FILL;
                cdgfd_pkg::INSTR_TILE:          o_status.op = cdgfd_pkg::OP_TILE;
                cdgfd_pkg::INSTR_TILE_XOR:      o_status.op = cdgfd_pkg::OP_XOR;
                default:                        o_status.op = cdgfd_pkg::OP_NONE;
            endcase
        end
    end

    assign w_sweep_last = (r_sx == XW'(cdgfd_pkg::SCREEN_COLUMNS - 1))
                       && (r_sy == YW'(cdgfd_pkg::SCREEN_ROWS - 1));
    assign w_tile_last  = (r_tp == 3'(cdgfd_pkg::TILE_COLS - 1))
                       && (r_tr == 4'(cdgfd_pkg::TILE_ROWS - 1));

    // sweep walks rows inside each column
    always_comb begin
        n_sx = r_sx;
        n_sy = r_sy;
        if (i_cmd.load) begin
            n_sx = '0;
            n_sy = '0;
        end else if (i_cmd.sweep_step) begin
            if (r_sy == YW'(cdgfd_pkg::SCREEN_ROWS - 1)) begin
                n_sy = '0;
                n_sx = (r_sx == XW'(cdgfd_pkg::SCREEN_COLUMNS - 1)) ? '0 : r_sx + 1'b1;
            end else begin
                n_sy = r_sy + 1'b1;
            end
        end
    end

    always_comb begin
        n_tp = r_tp;
        n_tr = r_tr;
        if (i_cmd.load) begin
            n_tp = '0;
            n_tr = '0;
        end else if (i_cmd.tile_step) begin
            if (r_tp == 3'(cdgfd_pkg::TILE_COLS - 1)) begin
                n_tp = '0;
                n_tr = (r_tr == 4'(cdgfd_pkg::TILE_ROWS - 1)) ? '0 : r_tr + 1'b1;
            end else begin
                n_tp = r_tp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0;
            r_sy <= '0;
            r_tp <= '0;
            r_tr <= '0;
        end else begin
            r_sx <= n_sx;
            r_sy <= n_sy;
            r_tp <= n_tp;
            r_tr <= n_tr;
        end
    end

    // item fields captured at accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_read    <= (i_opcode == cdgfd_pkg::OPC_READ);
            r_fill_inner <= (i_instruction == cdgfd_pkg::INSTR_MEM_PRESET);
            r_fill_color <= i_first_byte;
            r_color0     <= i_first_byte[3:0];
            r_color1     <= i_second_byte[3:0];
            r_tile_x0    <= TW'(i_fourth_byte) * TW'(cdgfd_pkg::TILE_COLS)
                          + TW'(cdgfd_pkg::INNER_X0);
            r_tile_y0    <= TW'(i_third_byte[4:0]) * TW'(cdgfd_pkg::TILE_ROWS)
                          + TW'(cdgfd_pkg::INNER_Y0);
            r_pattern    <= {i_pattern_bottom, i_pattern_top};
            r_rd_x       <= i_read_column;
            r_rd_y       <= i_read_row;
            r_rd_ok      <= (i_read_column < XW'(cdgfd_pkg::SCREEN_COLUMNS))
                         && (i_read_row < YW'(cdgfd_pkg::SCREEN_ROWS));
        end
    end

    assign w_tx      = r_tile_x0 + TW'(r_tp);
    assign w_ty      = r_tile_y0 + TW'(r_tr);
    assign w_tile_ok = (w_tx < TW'(cdgfd_pkg::SCREEN_COLUMNS))
                    && (w_ty < TW'(cdgfd_pkg::SCREEN_ROWS));

    // bit 5 of each pattern row is the leftmost pixel
    assign w_bit_idx    = PW'(r_tr) * PW'(cdgfd_pkg::TILE_COLS)
                        + PW'(cdgfd_pkg::TILE_COLS - 1) - PW'(r_tp);
    assign w_tile_color = r_pattern[w_bit_idx] ? {2'b00, r_color1} : {2'b00, r_color0};

    assign w_inner = (r_sx >= XW'(cdgfd_pkg::INNER_X0)) && (r_sx < XW'(cdgfd_pkg::INNER_X1))
                  && (r_sy >= YW'(cdgfd_pkg::INNER_Y0)) && (r_sy < YW'(cdgfd_pkg::INNER_Y1));

    always_comb begin
        case (i_cmd.addr_src)
            cdgfd_pkg::AS_SWEEP: begin
                w_ax = r_sx;
                w_ay = r_sy;
            end
            cdgfd_pkg::AS_TILE: begin
                w_ax = w_tx;
                w_ay = w_ty[YW-1:0];
            end
            cdgfd_pkg::AS_READ: begin
                w_ax = r_rd_x;
                w_ay = r_rd_y;
            end
            default: begin
                w_ax = r_sx;
                w_ay = r_sy;
            end
        endcase
    end

    // column-major layout
    assign w_addr = AW'(w_ax) * AW'(cdgfd_pkg::SCREEN_ROWS) + AW'(w_ay);

    always_comb begin
        case (i_cmd.wr_kind)
            cdgfd_pkg::WK_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = 6'd0;
            end
            cdgfd_pkg::WK_FILL: begin
                w_we    = (w_inner == r_fill_inner);
                w_wdata = r_fill_color;
            end
            cdgfd_pkg::WK_TILE: begin
                w_we    = w_tile_ok;
                w_wdata = w_tile_color;
            end
            cdgfd_pkg::WK_XOR: begin
                w_we    = w_tile_ok;
                w_wdata = r_rdata ^ w_tile_color;
            end
            default: begin
                w_we    = 1'b0;
                w_wdata = 6'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    assign o_pixel_color = (r_is_read && r_rd_ok) ? r_rdata : 6'd0;
    assign o_read_done   = r_is_read;

endmodule

/* hw/rtl/cdgfd_ctrl.sv */
// cdgfd_ctrl: sequencer for clearing, presets, tile painting and pixel reads
// depends on cdgfd_pkg
module cdgfd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  cdgfd_pkg::t_dp_status i_status,
    output cdgfd_pkg::t_dp_cmd    o_cmd,
    output logic                  o_busy,
    output logic                  o_valid
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_SWEEP  = 8'b0000_0100,
        S_TILE   = 8'b0000_1000,
        S_XOR_RD = 8'b0001_0000,
        S_XOR_WR = 8'b0010_0000,
        S_READ   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state          = r_state;
        o_cmd.load       = 1'b0;
        o_cmd.sweep_step = 1'b0;
        o_cmd.tile_step  = 1'b0;
        o_cmd.rd_en      = 1'b0;
        o_cmd.wr_en      = 1'b0;
        o_cmd.wr_kind    = cdgfd_pkg::WK_CLEAR;
        o_cmd.addr_src   = cdgfd_pkg::AS_SWEEP;
        case (r_state)
            S_CLEAR: begin
                o_cmd.wr_en      = 1'b1;
                o_cmd.sweep_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    case (i_status.op)
                        cdgfd_pkg::OP_READ: n_state = S_READ;
                        cdgfd_pkg::OP_FILL: n_state = S_SWEEP;
                        cdgfd_pkg::OP_TILE: n_state = S_TILE;
                        cdgfd_pkg::OP_XOR:  n_state = S_XOR_RD;
                        default:            n_state = S_DONE;
                    endcase
                end
            end
            S_SWEEP: begin
                o_cmd.wr_en      = 1'b1;
                o_cmd.wr_kind    = cdgfd_pkg::WK_FILL;
                o_cmd.sweep_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_TILE: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.wr_kind   = cdgfd_pkg::WK_TILE;
                o_cmd.addr_src  = cdgfd_pkg::AS_TILE;
                o_cmd.tile_step = 1'b1;
                if (i_status.tile_last) begin
                    n_state = S_DONE;
                end
            end
            S_XOR_RD: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_src = cdgfd_pkg::AS_TILE;
                n_state        = S_XOR_WR;
            end
            S_XOR_WR: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.wr_kind   = cdgfd_pkg::WK_XOR;
                o_cmd.addr_src  = cdgfd_pkg::AS_TILE;
                o_cmd.tile_step = 1'b1;
                n_state         = i_status.tile_last ? S_DONE : S_XOR_RD;
            end
            S_READ: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.addr_src = cdgfd_pkg::AS_READ;
                n_state        = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

/* hw/rtl/cdg_graphics_frame_decoder_unit.sv */
// cdg_graphics_frame_decoder_unit: top level of the cd+g frame decoder
// depends on cdgfd_pkg, cdgfd_ctrl and cdgfd_datapath
//
// usage:
//   an item is taken at a rising edge where start is high and busy is low.
//   opcode 0 carries a graphics packet, opcode 1 asks for one pixel of the
//   320x240 frame (6-bit color indices, stored column by column).
//   every item gives one result: o_valid is high for exactly one cycle with
//   o_pixel_color and o_read_done; the receiver has no way to hold it off.
// a pixel read, a tile, an xor tile (read then write per pixel on the single
// frame memory port), a memory or border preset (one pixel per cycle over the
// whole frame) and an ignored packet each run until the strobe. busy drops the
// cycle after the strobe, so the next item may start then.
// reset (synchronous, active low) starts a clearing pass over the whole frame
// that zeroes it; busy stays high until it ends.
module cdg_graphics_frame_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [5:0]  i_instruction,
    input  logic [5:0]  i_first_byte,
    input  logic [5:0]  i_second_byte,
    input  logic [5:0]  i_third_byte,
    input  logic [5:0]  i_fourth_byte,
    input  logic [35:0] i_pattern_top,
    input  logic [35:0] i_pattern_bottom,
    input  logic [8:0]  i_read_column,
    input  logic [7:0]  i_read_row,
    output logic        o_valid,
    output logic [5:0]  o_pixel_color,
    output logic        o_read_done
);

    cdgfd_pkg::t_dp_cmd    w_cmd;
    cdgfd_pkg::t_dp_status w_status;

    cdgfd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    cdgfd_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_opcode         (i_opcode),
        .i_instruction    (i_instruction),
        .i_first_byte     (i_first_byte),
        .i_second_byte    (i_second_byte),
        .i_third_byte     (i_third_byte),
        .i_fourth_byte    (i_fourth_byte),
        .i_pattern_top    (i_pattern_top),
        .i_pattern_bottom (i_pattern_bottom),
        .i_read_column    (i_read_column),
        .i_read_row       (i_read_row),
        .o_pixel_color    (o_pixel_color),
        .o_read_done      (o_read_done)
    );

    // the frame is only written while an item or the clearing pass is running
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !w_cmd.wr_en)
        else $error("frame write while idle");

    // an accepted item keeps the block busy until its result
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // the result strobe ends the item
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!busy && !o_valid))
        else $error("block still busy after result");

endmodule

/* tb/tb.sv */
// tb: self-checking testbench for cdg_graphics_frame_decoder_unit, predicts every
// pixel read and packet result from its own copy of the 320x240 frame
// depends on cdgfd_pkg and the rtl of the frame decoder
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS  = 80;
    localparam int unsigned TAIL_ITEMS    = 12;
    localparam int unsigned QUIET_LIMIT   = 320000;
    localparam int unsigned SETTLE_CYCLES = 200;

    // instruction values that the decoder leaves alone
    localparam logic [5:0] INSTR_IGNORED_LOW  = 6'd0;
    localparam logic [5:0] INSTR_IGNORED_HIGH = 6'd63;

    typedef struct {
        logic        opcode;
        logic [5:0]  instruction;
        logic [5:0]  first_byte;
        logic [5:0]  second_byte;
        logic [5:0]  third_byte;
        logic [5:0]  fourth_byte;
        logic [35:0] pattern_top;
        logic [35:0] pattern_bottom;
        logic [8:0]  read_column;
        logic [7:0]  read_row;
        bit          wait_idle;
    } t_item;

    typedef struct {
        logic [5:0] pixel_color;
        logic       read_done;
    } t_pixel_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_opcode = 1'b0;
    logic [5:0]  i_instruction = '0;
    logic [5:0]  i_first_byte = '0;
    logic [5:0]  i_second_byte = '0;
    logic [5:0]  i_third_byte = '0;
    logic [5:0]  i_fourth_byte = '0;
    logic [35:0] i_pattern_top = '0;
    logic [35:0] i_pattern_bottom = '0;
    logic [8:0]  i_read_column = '0;
    logic [7:0]  i_read_row = '0;
    logic        o_valid;
    logic [5:0]  o_pixel_color;
    logic        o_read_done;

    cdg_graphics_frame_decoder_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_instruction    (i_instruction),
        .i_first_byte     (i_first_byte),
        .i_second_byte    (i_second_byte),
        .i_third_byte     (i_third_byte),
        .i_fourth_byte    (i_fourth_byte),
        .i_pattern_top    (i_pattern_top),
        .i_pattern_bottom (i_pattern_bottom),
        .i_read_column    (i_read_column),
        .i_read_row       (i_read_row),
        .o_valid          (o_valid),
        .o_pixel_color    (o_pixel_color),
        .o_read_done      (o_read_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bit [5:0]      frame_colors [cdgfd_pkg::FRAME_SIZE];
    t_item         pending_items [$];
    t_pixel_result expected_pixels [$];
    t_item         next_item;
    t_item         driven_item;
    logic          item_taken = 1'b0;
    int unsigned   hold_cycles = 0;
    int unsigned   quiet_cycles = 0;
    bit            mismatch_seen = 1'b0;
    bit            drain_first = 1'b0;
    int unsigned   last_x0 = 10;
    int unsigned   last_y0 = 12;

    // ---------------------------------------------------------------- predictor

    function automatic void fill_frame(logic [5:0] color, bit inner);
        bit in_area;
        for (int x = 0; x < cdgfd_pkg::SCREEN_COLUMNS; x++) begin
            for (int y = 0; y < cdgfd_pkg::SCREEN_ROWS; y++) begin
                in_area = x >= cdgfd_pkg::INNER_X0 && x < cdgfd_pkg::INNER_X1
                       && y >= cdgfd_pkg::INNER_Y0 && y < cdgfd_pkg::INNER_Y1;
                if (in_area == inner)
                    frame_colors[x * cdgfd_pkg::SCREEN_ROWS + y] = color;
            end
        end
    endfunction

    function automatic void paint_tile(t_item it, bit use_xor);
        logic [3:0]  color0;
        logic [3:0]  color1;
        logic [3:0]  color;
        logic [5:0]  row_bits;
        int unsigned x0;
        int unsigned y0;
        int unsigned x;
        int unsigned y;
        int unsigned idx;
        color0 = it.first_byte[3:0];
        color1 = it.second_byte[3:0];
        x0 = it.fourth_byte * 6 + 10;
        y0 = it.third_byte[4:0] * 12 + 12;
        for (int r = 0; r < cdgfd_pkg::TILE_ROWS; r++) begin
            if (r < 6)
                row_bits = it.pattern_top[(r % 6) * 6 +: 6];
            else
                row_bits = it.pattern_bottom[(r % 6) * 6 +: 6];
            y = y0 + r;
            if (y < cdgfd_pkg::SCREEN_ROWS) begin
                for (int p = 0; p < cdgfd_pkg::TILE_COLS; p++) begin
                    x = x0 + p;
                    if (x < cdgfd_pkg::SCREEN_COLUMNS) begin
                        // bit 5 of a pattern row is the leftmost pixel
                        color = row_bits[5 - p] ? color1 : color0;
                        idx = x * cdgfd_pkg::SCREEN_ROWS + y;
                        if (use_xor)
                            frame_colors[idx] = frame_colors[idx] ^ {2'b00, color};
                        else
                            frame_colors[idx] = {2'b00, color};
                    end
                end
            end
        end
    endfunction

    function automatic t_pixel_result frame_apply_item(t_item it);
        t_pixel_result res;
        res.pixel_color = '0;
        res.read_done = 1'b0;
        if (it.opcode == cdgfd_pkg::OPC_READ) begin
            res.read_done = 1'b1;
            if (it.read_column < cdgfd_pkg::SCREEN_COLUMNS
                && it.read_row < cdgfd_pkg::SCREEN_ROWS)
                res.pixel_color =
                    frame_colors[it.read_column * cdgfd_pkg::SCREEN_ROWS + it.read_row];
        end else begin
            case (it.instruction)
                cdgfd_pkg::INSTR_MEM_PRESET: begin
                    if (it.second_byte == 6'd0)
                        fill_frame(it.first_byte, 1'b1);
                end
                cdgfd_pkg::INSTR_BORDER_PRESET: fill_frame(it.first_byte, 1'b0);
                cdgfd_pkg::INSTR_TILE:          paint_tile(it, 1'b0);
                cdgfd_pkg::INSTR_TILE_XOR:      paint_tile(it, 1'b1);
                default: ;
            endcase
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [35:0] rand_pattern();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[35:0];
    endfunction

    task automatic add_packet(logic [5:0] instr, logic [5:0] b0, logic [5:0] b1,
                              logic [5:0] b2, logic [5:0] b3,
                              logic [35:0] top, logic [35:0] bottom);
        t_item it;
        it.opcode         = cdgfd_pkg::OPC_PACKET;
        it.instruction    = instr;
        it.first_byte     = b0;
        it.second_byte    = b1;
        it.third_byte     = b2;
        it.fourth_byte    = b3;
        it.pattern_top    = top;
        it.pattern_bottom = bottom;
        it.read_column    = 9'($urandom_range(0, 511));
        it.read_row       = 8'($urandom_range(0, 255));
        it.wait_idle      = drain_first;
        drain_first = 1'b0;
        pending_items.push_back(it);
    endtask

    task automatic add_read(logic [8:0] x, logic [7:0] y);
        t_item it;
        it.opcode         = cdgfd_pkg::OPC_READ;
        it.instruction    = 6'($urandom_range(0, 63));
        it.first_byte     = 6'($urandom_range(0, 63));
        it.second_byte    = 6'($urandom_range(0, 63));
        it.third_byte     = 6'($urandom_range(0, 63));
        it.fourth_byte    = 6'($urandom_range(0, 63));
        it.pattern_top    = rand_pattern();
        it.pattern_bottom = rand_pattern();
        it.read_column    = x;
        it.read_row       = y;
        it.wait_idle      = drain_first;
        drain_first = 1'b0;
        pending_items.push_back(it);
    endtask

    task automatic add_random_tile(logic [5:0] instr);
        logic [5:0] trow;
        logic [5:0] tcol;
        // mostly on-screen tiles so reads can find them, some fully random
        if ($urandom_range(0, 4) == 0) begin
            trow = 6'($urandom_range(0, 63));
            tcol = 6'($urandom_range(0, 63));
        end else begin
            trow = 6'($urandom_range(0, 18));
            tcol = 6'($urandom_range(0, 51));
        end
        last_x0 = tcol * 6 + 10;
        last_y0 = trow[4:0] * 12 + 12;
        add_packet(instr, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                   trow, tcol, rand_pattern(), rand_pattern());
    endtask

    // ---------------------------------------------------------------- driver

    always @(negedge i_clk) begin
        if (i_rst_n && (!start || item_taken)) begin
            if (hold_cycles != 0) begin
                start <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].wait_idle && expected_pixels.size() != 0)) begin
                next_item = pending_items.pop_front();
                driven_item = next_item;
                i_opcode         <= next_item.opcode;
                i_instruction    <= next_item.instruction;
                i_first_byte     <= next_item.first_byte;
                i_second_byte    <= next_item.second_byte;
                i_third_byte     <= next_item.third_byte;
                i_fourth_byte    <= next_item.fourth_byte;
                i_pattern_top    <= next_item.pattern_top;
                i_pattern_bottom <= next_item.pattern_bottom;
                i_read_column    <= next_item.read_column;
                i_read_row       <= next_item.read_row;
                start <= 1'b1;
                // gap after this item once it is taken, none near the end
                if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0)
                    hold_cycles <= $urandom_range(1, 7);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        t_pixel_result want;
        if (!i_rst_n) begin
            item_taken <= 1'b0;
        end else begin
            if (o_valid) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: result with no item outstanding, pixel_color %0d read_done %0b",
                             $time, o_pixel_color, o_read_done);
                    mismatch_seen = 1'b1;
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_pixel_color !== want.pixel_color) begin
                        $display("%0t: pixel_color expected %0d actual %0d",
                                 $time, want.pixel_color, o_pixel_color);
                        mismatch_seen = 1'b1;
                    end
                    if (o_read_done !== want.read_done) begin
                        $display("%0t: read_done expected %0b actual %0b",
                                 $time, want.read_done, o_read_done);
                        mismatch_seen = 1'b1;
                    end
                end
            end
            item_taken <= start && !busy;
            if (start && !busy)
                expected_pixels.push_back(frame_apply_item(driven_item));
        end
    end

    // watchdog on cycles with neither an item taken nor a result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- test sequence

    initial begin
        int unsigned pick;
        int unsigned presets_left;
        int unsigned x;
        int unsigned y;

        // fresh frame is all zero, reads past the edge give zero
        add_read(9'd0, 8'd0);
        add_read(9'd319, 8'd239);
        add_read(9'd320, 8'd0);
        add_read(9'd511, 8'd255);
        add_packet(cdgfd_pkg::INSTR_MEM_PRESET, 6'd63, 6'd0, 6'd0, 6'd0, '0, '0);
        add_read(9'd10, 8'd12);
        add_read(9'd9, 8'd12);
        add_read(9'd309, 8'd227);
        // memory preset with a repeat count leaves the frame alone
        add_packet(cdgfd_pkg::INSTR_MEM_PRESET, 6'd5, 6'd1, 6'd63, 6'd63, '1, '1);
        add_read(9'd100, 8'd100);
        add_packet(cdgfd_pkg::INSTR_BORDER_PRESET, 6'd42, 6'd63, 6'd0, 6'd0, '0, '0);
        add_read(9'd0, 8'd0);
        add_read(9'd10, 8'd11);
        add_packet(cdgfd_pkg::INSTR_TILE, 6'h3A, 6'h35, 6'd0, 6'd0,
                   36'hFFF000FFF, 36'h000FFF000);
        add_read(9'd10, 8'd12);
        add_read(9'd15, 8'd23);
        // tile hanging over the right edge, sent once the decoder has drained
        drain_first = 1'b1;
        add_packet(cdgfd_pkg::INSTR_TILE, 6'h0F, 6'h30, 6'd18, 6'd51, '1, '0);
        add_read(9'd319, 8'd239);
        // row and column beyond the frame: every pixel dropped
        add_packet(cdgfd_pkg::INSTR_TILE_XOR, 6'h3F, 6'h2A, 6'd63, 6'd63, '1, '1);
        add_packet(cdgfd_pkg::INSTR_TILE_XOR, 6'h05, 6'h3C, 6'd18, 6'd51,
                   36'hAAAAAAAAA, 36'h555555555);
        add_read(9'd318, 8'd235);
        add_read(9'd316, 8'd228);
        add_packet(INSTR_IGNORED_LOW, 6'd63, 6'd63, 6'd63, 6'd63, '1, '1);
        add_packet(INSTR_IGNORED_HIGH, 6'd0, 6'd0, 6'd0, 6'd0, '0, '0);
        add_read(9'd316, 8'd228);

        presets_left = 3;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0)
                drain_first = 1'b1;
            if (pick < 40) begin
                // read back somewhere in the most recent tile when it is on screen
                x = last_x0 + $urandom_range(0, 5);
                y = last_y0 + $urandom_range(0, 11);
                if ($urandom_range(0, 2) == 0 || x >= cdgfd_pkg::SCREEN_COLUMNS
                    || y >= cdgfd_pkg::SCREEN_ROWS) begin
                    x = $urandom_range(0, cdgfd_pkg::SCREEN_COLUMNS - 1);
                    y = $urandom_range(0, cdgfd_pkg::SCREEN_ROWS - 1);
                end
                add_read(9'(x), 8'(y));
            end else if (pick < 65) begin
                add_random_tile(cdgfd_pkg::INSTR_TILE);
            end else if (pick < 80) begin
                add_random_tile(cdgfd_pkg::INSTR_TILE_XOR);
            end else if (pick < 88) begin
                pick = $urandom_range(0, 63);
                if (pick == cdgfd_pkg::INSTR_MEM_PRESET || pick == cdgfd_pkg::INSTR_BORDER_PRESET
                    || pick == cdgfd_pkg::INSTR_TILE || pick == cdgfd_pkg::INSTR_TILE_XOR)
                    pick = INSTR_IGNORED_LOW;
                add_packet(6'(pick), 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                           6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                           rand_pattern(), rand_pattern());
            end else if (pick < 92 && presets_left != 0) begin
                // presets sweep the whole frame, so only a few of them
                presets_left--;
                if ($urandom_range(0, 1) == 0)
                    add_packet(cdgfd_pkg::INSTR_MEM_PRESET, 6'($urandom_range(0, 63)),
                               ($urandom_range(0, 2) == 0) ? 6'($urandom_range(1, 63)) : 6'd0,
                               6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                               rand_pattern(), rand_pattern());
                else
                    add_packet(cdgfd_pkg::INSTR_BORDER_PRESET, 6'($urandom_range(0, 63)),
                               6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                               6'($urandom_range(0, 63)), rand_pattern(), rand_pattern());
            end else begin
                add_read(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
            end
        end

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_items.size() != 0 || start)
            @(negedge i_clk);
        while (expected_pixels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (!mismatch_seen)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/cdgfd_pkg.sv
hw/rtl/cdgfd_datapath.sv
hw/rtl/cdgfd_ctrl.sv
hw/rtl/cdg_graphics_frame_decoder_unit.sv
tb/tb.sv
